// ===== hdl/sliding_window_sender_control_top_assert.svh =====
// Assertion macros for the sliding window sender control checker.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef SLIDING_WINDOW_SENDER_CONTROL_TOP_ASSERT_SVH
`define SLIDING_WINDOW_SENDER_CONTROL_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SWSC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SWSC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/swsc_pkg.sv =====
// Shared types and constants of the sliding window sender control.
// No dependencies; imported by every module of the block.
package swsc_pkg;

    // byte number to packet number: PACKET_BYTES is 1024
    localparam int          ACK_SHIFT   = 10;
    localparam logic [11:0] MAX_PACKETS = 12'd2048;
    localparam logic [6:0]  WINDOW_CAP  = 7'd64;
    localparam logic [7:0]  DUP_TRIGGER = 8'd3;
    localparam logic [11:0] INDEX_MAX   = 12'hFFF;

    // reset values of the configuration registers
    localparam logic [6:0]  WINDOW_RST  = 7'd10;
    localparam logic [7:0]  RETRY_RST   = 8'd100;
    localparam logic [11:0] TOTAL_RST   = 12'd0;

    typedef enum logic [1:0] {
        OP_KICK    = 2'd0,
        OP_ACK     = 2'd1,
        OP_TIMEOUT = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        K_SEND    = 3'd0,
        K_DUP_RTX = 3'd1,
        K_TO_RTX  = 3'd2,
        K_EOF     = 3'd3,
        K_DONE    = 3'd4,
        K_GAVE_UP = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        CFG_WINDOW = 2'd0,
        CFG_RETRY  = 2'd1,
        CFG_TOTAL  = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [6:0]  window;
        logic [7:0]  retry;
        logic [11:0] total;
    } t_cfg;

    // one classified item, handed from the front to the back
    typedef struct packed {
        logic        pre_valid;   // leading command present
        t_kind       pre_kind;
        logic        eof_valid;   // end of file after the leading command
        logic        fill_en;     // run the window fill
        logic        eof_fill;    // window fill ends in end of file
        logic        set_next;    // next index restarts at base
        logic [11:0] base;
        logic [6:0]  win;
        logic [11:0] total;
    } t_job;

endpackage

// ===== hdl/sliding_window_sender_control_top.sv =====
// Top level of the sliding window sender control: config registers, front, queue, back.
// Depends on swsc_pkg, swsc_front, swsc_queue and swsc_back.
//
//  channel   direction  contents
//  s (item)  in         tdata: ack_byte; tuser: op, ack_final
//  m (cmd)   out        tdata: packet_index, timer_start; tuser: kind; tlast: last
//  cfg       in         index 0 window_packets, 1 retry_limit, 2 packet_total
//
// The front takes an item whenever the job queue has room and stalls only when it is full.
// The back fetches a job in its idle state, then steps through the leading command, end of
// file and one fill step per packet sent, each step waiting while the output is stalled.
// Synchronous reset clears all control state directly; there is no clearing pass.
// A stalled command output holds the back end; items keep queueing until the queue is full.
module sliding_window_sender_control_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,    // [31:0] ack_byte
    input  logic [2:0]  i_s_tuser,    // [1:0] op, [2] ack_final
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,    // [11:0] packet_index, [12] timer_start, [15:13] zero
    output logic [2:0]  o_m_tuser,    // [2:0] kind
    output logic        o_m_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [11:0] i_cfg_data
);
    import swsc_pkg::*;

    t_cfg        r_cfg;
    logic        q_push;
    t_job        q_wr_job;
    logic        q_full;
    logic        q_pop;
    t_job        q_rd_job;
    logic        q_empty;
    t_kind       m_kind;
    logic [11:0] m_index;
    logic        m_timer;

    // configuration registers, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window <= WINDOW_RST;
            r_cfg.retry  <= RETRY_RST;
            r_cfg.total  <= TOTAL_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_WINDOW: r_cfg.window <= i_cfg_data[6:0];
                CFG_RETRY:  r_cfg.retry  <= i_cfg_data[7:0];
                CFG_TOTAL:  r_cfg.total  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    swsc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (i_s_tvalid),
        .o_ready     (o_s_tready),
        .i_op        (i_s_tuser[1:0]),
        .i_ack_byte  (i_s_tdata),
        .i_ack_final (i_s_tuser[2]),
        .i_full      (q_full),
        .o_push      (q_push),
        .o_job       (q_wr_job)
    );

    swsc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wr_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rd_job),
        .o_empty (q_empty)
    );

    swsc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_job   (q_rd_job),
        .o_pop   (q_pop),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_kind  (m_kind),
        .o_index (m_index),
        .o_timer (m_timer),
        .o_last  (o_m_tlast)
    );

    assign o_m_tdata = {3'b000, m_timer, m_index};
    assign o_m_tuser = m_kind;

endmodule

// ===== hdl/swsc_front.sv =====
// Front end: accepts items, keeps ack/retry/dup state, and builds at most one job per item.
// Depends on swsc_pkg.
module swsc_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  swsc_pkg::t_cfg    i_cfg,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_op,
    input  logic [31:0]       i_ack_byte,
    input  logic              i_ack_final,
    input  logic              i_full,
    output logic              o_push,
    output swsc_pkg::t_job    o_job
);
    import swsc_pkg::*;

    localparam int BLK_W = 32 - ACK_SHIFT;

    // last acknowledged index is base - 1 once any ack was seen, zero before
    logic        r_halted, n_halted;
    logic        r_acked, n_acked;
    logic [11:0] r_base, n_base;
    logic [31:0] r_prev_ack, n_prev_ack;
    logic [7:0]  r_dup_count, n_dup_count;
    logic        r_dup_block, n_dup_block;
    logic [7:0]  r_retry, n_retry;

    logic [6:0]       win;
    logic [11:0]      total;
    logic [BLK_W-1:0] ack_blk;
    logic [11:0]      ack_base;
    logic             eof_kick;
    logic             eof_to;
    logic             dup_hit;
    logic [7:0]       dup_next;
    logic             accept;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;

    // effective limits and packet number of the ack
    always_comb begin
        win      = (i_cfg.window > WINDOW_CAP) ? WINDOW_CAP : i_cfg.window;
        total    = (i_cfg.total > MAX_PACKETS) ? MAX_PACKETS : i_cfg.total;
        ack_blk  = i_ack_byte[31:ACK_SHIFT];
        ack_base = (ack_blk[BLK_W-1:12] != '0) ? INDEX_MAX : ack_blk[11:0];
        eof_kick = r_acked ? (r_base >= total) : (total <= 12'd1);
        eof_to   = r_acked ? (({1'b0, r_base} + 13'd1) >= {1'b0, total})
                           : (total <= 12'd2);
        dup_hit  = (i_ack_byte == r_prev_ack);
        if (!dup_hit) begin
            dup_next = 8'd0;
        end else if (r_dup_count == 8'hFF) begin
            dup_next = r_dup_count;
        end else begin
            dup_next = r_dup_count + 8'd1;
        end
    end

    // classify the item and update state
    always_comb begin
        n_halted    = r_halted;
        n_acked     = r_acked;
        n_base      = r_base;
        n_prev_ack  = r_prev_ack;
        n_dup_count = r_dup_count;
        n_dup_block = r_dup_block;
        n_retry     = r_retry;
        o_push      = 1'b0;
        o_job       = '{pre_valid: 1'b0, pre_kind: K_SEND, eof_valid: 1'b0,
                        fill_en: 1'b0, eof_fill: 1'b0, set_next: 1'b0,
                        base: r_base, win: win, total: total};
        if (accept && !r_halted) begin
            case (i_op)
                OP_KICK: begin
                    o_push         = 1'b1;
                    o_job.fill_en  = !r_dup_block;
                    o_job.eof_fill = eof_kick;
                end
                OP_ACK: begin
                    o_push         = 1'b1;
                    n_retry        = 8'd0;
                    n_base         = ack_base;
                    n_acked        = 1'b1;
                    o_job.base     = ack_base;
                    o_job.set_next = 1'b1;
                    if (i_ack_final) begin
                        n_halted        = 1'b1;
                        o_job.pre_valid = 1'b1;
                        o_job.pre_kind  = K_DONE;
                    end else begin
                        n_dup_block    = dup_hit;
                        n_prev_ack     = i_ack_byte;
                        n_dup_count    = dup_next;
                        o_job.fill_en  = !dup_hit;
                        o_job.eof_fill = (ack_base >= total);
                        // third repeat in a row: fast retransmit
                        if ((dup_next >= DUP_TRIGGER) && (ack_base < total)) begin
                            o_job.pre_valid = 1'b1;
                            o_job.pre_kind  = K_DUP_RTX;
                            n_dup_count     = 8'd0;
                        end
                    end
                end
                OP_TIMEOUT: begin
                    o_push = 1'b1;
                    if (r_retry < i_cfg.retry) begin
                        n_retry         = r_retry + 8'd1;
                        o_job.pre_valid = (r_base < total);
                        o_job.pre_kind  = K_TO_RTX;
                        o_job.eof_valid = eof_to;
                    end else begin
                        n_halted        = 1'b1;
                        o_job.pre_valid = 1'b1;
                        o_job.pre_kind  = K_GAVE_UP;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_halted    <= 1'b0;
            r_acked     <= 1'b0;
            r_base      <= '0;
            r_prev_ack  <= '0;
            r_dup_count <= '0;
            r_dup_block <= 1'b0;
            r_retry     <= '0;
        end else begin
            r_halted    <= n_halted;
            r_acked     <= n_acked;
            r_base      <= n_base;
            r_prev_ack  <= n_prev_ack;
            r_dup_count <= n_dup_count;
            r_dup_block <= n_dup_block;
            r_retry     <= n_retry;
        end
    end

endmodule

// ===== hdl/swsc_queue.sv =====
// Short job queue between front and back end.
// Depends on swsc_pkg.
module swsc_queue #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  swsc_pkg::t_job i_data,
    output logic           o_full,
    input  logic           i_pop,
    output swsc_pkg::t_job o_data,
    output logic           o_empty
);
    import swsc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // pointer and count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ===== hdl/swsc_back.sv =====
// Back end: runs one job at a time and emits its commands through an output register.
// Depends on swsc_pkg.
module swsc_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  swsc_pkg::t_job  i_job,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output swsc_pkg::t_kind o_kind,
    output logic [11:0]     o_index,
    output logic            o_timer,
    output logic            o_last
);
    import swsc_pkg::*;

    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_PRE  = 4'b0010,
        B_EOF  = 4'b0100,
        B_FILL = 4'b1000
    } t_bstate;

    t_bstate     r_state, n_state;
    t_job        r_job, n_job;
    logic [11:0] r_nx, n_nx;
    logic        r_out_valid;
    t_kind       r_out_kind;
    logic [11:0] r_out_idx;
    logic        r_out_tmr;
    logic        r_out_last;

    logic        out_free;
    logic [11:0] nx_inc;
    logic        emit_now;
    logic        emit_nxt;
    logic        load;
    t_kind       ld_kind;
    logic [11:0] ld_idx;
    logic        ld_tmr;
    logic        ld_last;

    // does one more fill step at index nx produce a command
    function automatic logic fill_emit(input t_job j, input logic [11:0] nx);
        logic [12:0] lim;
        lim = {1'b0, j.base} + {6'b0, j.win};
        return j.fill_en && ({1'b0, nx} < lim) && (j.eof_fill || (nx < j.total));
    endfunction

    assign out_free = !r_out_valid || i_ready;
    assign nx_inc   = r_nx + 12'd1;
    assign emit_now = fill_emit(r_job, r_nx);
    assign emit_nxt = fill_emit(r_job, nx_inc);

    // job sequencer: leading command, end of file, then window fill
    always_comb begin
        n_state = r_state;
        n_job   = r_job;
        n_nx    = r_nx;
        o_pop   = 1'b0;
        load    = 1'b0;
        ld_kind = K_SEND;
        ld_idx  = '0;
        ld_tmr  = 1'b0;
        ld_last = 1'b0;
        case (r_state)
            B_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_job   = i_job;
                    n_state = B_PRE;
                    if (i_job.set_next) begin
                        n_nx = i_job.base;
                    end
                end
            end
            B_PRE: begin
                if (out_free) begin
                    n_state = B_EOF;
                    if (r_job.pre_valid) begin
                        load    = 1'b1;
                        ld_kind = r_job.pre_kind;
                        ld_tmr  = (r_job.pre_kind == K_DUP_RTX) ||
                                  (r_job.pre_kind == K_TO_RTX);
                        ld_idx  = ld_tmr ? r_job.base : 12'd0;
                        ld_last = !r_job.eof_valid && !emit_now;
                    end
                end
            end
            B_EOF: begin
                if (out_free) begin
                    n_state = B_FILL;
                    if (r_job.eof_valid) begin
                        load    = 1'b1;
                        ld_kind = K_EOF;
                        ld_last = !emit_now;
                    end
                end
            end
            B_FILL: begin
                if (out_free) begin
                    if (!emit_now) begin
                        n_state = B_IDLE;
                    end else if (r_job.eof_fill) begin
                        load    = 1'b1;
                        ld_kind = K_EOF;
                        ld_last = 1'b1;
                        n_state = B_IDLE;
                    end else begin
                        load    = 1'b1;
                        ld_kind = K_SEND;
                        ld_idx  = r_nx;
                        ld_tmr  = (r_job.base == r_nx);
                        ld_last = !emit_nxt;
                        n_nx    = nx_inc;
                        if (!emit_nxt) begin
                            n_state = B_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_nx    <= '0;
        end else begin
            r_state <= n_state;
            r_nx    <= n_nx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_kind <= ld_kind;
            r_out_idx  <= ld_idx;
            r_out_tmr  <= ld_tmr;
            r_out_last <= ld_last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_kind  = r_out_kind;
    assign o_index = r_out_idx;
    assign o_timer = r_out_tmr;
    assign o_last  = r_out_last;

endmodule

// ===== hdl/swsc_checker.sv =====
// Port-level checker for the sliding window sender control, bound to the top level.
// Depends on swsc_pkg and sliding_window_sender_control_top_assert.svh.
`include "sliding_window_sender_control_top_assert.svh"

module swsc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] o_m_tdata,
    input logic [2:0]  o_m_tuser,
    input logic        o_m_tlast
);
    import swsc_pkg::*;

    // a stalled command stays offered
    `SWSC_ASSERT_NEXT(a_hold_valid, o_m_tvalid && !i_m_tready, o_m_tvalid, "command dropped while stalled")

    // a stalled command keeps its payload
    `SWSC_ASSERT_NEXT(a_hold_data, o_m_tvalid && !i_m_tready, $stable(o_m_tdata) && $stable(o_m_tuser) && $stable(o_m_tlast), "command changed while stalled")

    // end of file, finished and gave up carry no packet and no timer start
    `SWSC_ASSERT_NOW(a_ctrl_zero, o_m_tvalid && (o_m_tuser == K_EOF || o_m_tuser == K_DONE || o_m_tuser == K_GAVE_UP), o_m_tdata == 16'd0, "control command with payload")

    // both retransmit kinds restart the timer
    `SWSC_ASSERT_NOW(a_rtx_timer, o_m_tvalid && (o_m_tuser == K_DUP_RTX || o_m_tuser == K_TO_RTX), o_m_tdata[12], "retransmit without timer start")

    // finished and gave up always close the item
    `SWSC_ASSERT_NOW(a_halt_last, o_m_tvalid && (o_m_tuser == K_DONE || o_m_tuser == K_GAVE_UP), o_m_tlast, "halt command not last")

endmodule

bind sliding_window_sender_control_top swsc_checker u_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);
